FILE: rtl/nds_pkg.sv
// Shared constants, widths and table-building helpers for the sigmoid neuron.
package nds_pkg;

    // Parameter defaults
    localparam int MAX_INPUTS_DEF          = 512;
    localparam int SIGMOID_TABLE_DEPTH_DEF = 512;

    // Fixed field widths
    localparam int MODE_W   = 1;
    localparam int WIDX_W   = 9;
    localparam int VALUE_W  = 16;
    localparam int ACT_W    = 16;
    localparam int COUNT_W  = 10;
    localparam int BIAS_W   = 16;
    localparam int ACC_W    = 48;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Sum of accumulator and shifted bias, and its table index before clamping
    localparam int SUM_W      = ACC_W + 1;
    localparam int BIAS_SHIFT = 12;
    localparam int IDX_SHIFT  = 19;
    localparam int IDX_W      = SUM_W - IDX_SHIFT;

    // Result buffer
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_WEIGHT = 1'b0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS        = 1'b1;

    // Q30 constants for the table build
    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF  = 64'd1 << 29;
    localparam logic [63:0] POW_CAP   = 64'd1 << 52;
    localparam logic [63:0] E_Q30     = (64'd271828 << 30) / 64'd100000;
    localparam logic [63:0] U32_MAX   = 64'hFFFF_FFFF;
    localparam logic [63:0] R_NUM_OFS = 64'd1 << 47;
    localparam logic [63:0] ACT_FULL  = 64'd65536;
    localparam logic [63:0] ACT_SAT   = 64'd65535;

    // a^32 in Q30 by five squarings; stop once an operand leaves 32 bits
    function automatic logic [63:0] pow32_q30(input logic [63:0] m);
        logic [63:0] a;
        logic        stop;
        a    = m;
        stop = 1'b0;
        for (int i = 0; i < 5; i++) begin
            if (!stop) begin
                if (a > U32_MAX) begin
                    stop = 1'b1;
                end else begin
                    a = (a * a + Q30_HALF) >> 30;
                end
            end
        end
        return a;
    endfunction

    // Q30 product, rounded half up
    function automatic logic [63:0] mul_q30(input logic [63:0] p, input logic [63:0] q);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = p >> 30;
        lo = p & (Q30_ONE - 64'd1);
        return hi * q + ((lo * q + Q30_HALF) >> 30);
    endfunction

    // Shift-and-subtract quotient, used only while building constants
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= dv) begin
                rem    = rem - dv;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Largest Q30 base in [1, 2] whose 32nd power stays at or below e
    function automatic logic [63:0] exp_step_q30();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = Q30_ONE;
        hi = Q30_ONE << 1;
        for (int i = 0; i < 40; i++) begin
            if (hi - lo > 64'd1) begin
                mid = lo + ((hi - lo) >> 1);
                if (pow32_q30(mid) <= E_Q30) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
        end
        return lo;
    endfunction

endpackage

FILE: rtl/neuron_dot_product_sigmoid.sv
// Top level: single neuron with weight memory, multiply-accumulate and sigmoid ROM.
//
// One neuron. A beat with mode 0 writes its value as a Q3.12 weight at
// weight_index (indexes beyond the weight store are dropped). A beat with mode 1
// is one Q3.12 sample: it is multiplied by the weight for the current position
// and added into a 48-bit wrapping accumulator. The beat that brings the
// position up to input_count (0 counts as 1, values above MAX_INPUTS count as
// MAX_INPUTS) closes the vector: bias is added, the sum indexes a sigmoid ROM in
// steps of 1/32 over [-8, 8), and one Q0.16 activation goes out on m_. Weight
// beats and the other samples return nothing. The block takes one beat per
// clock while s_ready is high; this is set by the single port of the weight
// memory, read once per sample, and by the accumulator add that closes on
// itself each cycle. A result for the beat that closed its vector passes
// through weight read, multiply, accumulate, bias and clamp, ROM read, then an
// eight-entry result buffer. s_ready falls only while eight results are
// outstanding (in flight or waiting in the buffer). Weights come up undefined
// after reset and must be loaded before use; write input_count and bias only
// while the block is idle.
module neuron_dot_product_sigmoid #(
    parameter int MAX_INPUTS          = nds_pkg::MAX_INPUTS_DEF,
    parameter int SIGMOID_TABLE_DEPTH = nds_pkg::SIGMOID_TABLE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [nds_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nds_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [nds_pkg::MODE_W-1:0]           s_mode,
    input  logic [nds_pkg::WIDX_W-1:0]           s_weight_index,
    input  logic signed [nds_pkg::VALUE_W-1:0]   s_value,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [nds_pkg::ACT_W-1:0]            m_activation
);

    import nds_pkg::*;

    localparam int AW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int PW   = $clog2(MAX_INPUTS + 1);
    localparam int CW   = (PW > COUNT_W) ? PW : COUNT_W;
    localparam int HALF = SIGMOID_TABLE_DEPTH / 2;
    localparam int TIW  = $clog2(SIGMOID_TABLE_DEPTH);

    typedef logic [ACT_W-1:0] sig_tab_t [SIGMOID_TABLE_DEPTH];

    // Build the sigmoid table: entry -k is 1/(1+e^(k/32)), entry k is 1 - that
    function automatic sig_tab_t build_sig_table();
        sig_tab_t    t;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] r;
        logic [63:0] pos;
        q = exp_step_q30();
        p = Q30_ONE;
        t = '{default: '0};
        for (int k = 0; k <= HALF; k++) begin
            if (k > 0) begin
                p = mul_q30(p, q);
                if (p > POW_CAP) begin
                    p = POW_CAP;
                end
            end
            d   = p + Q30_ONE;
            r   = udiv64(R_NUM_OFS + d, d << 1);
            pos = ACT_FULL - r;
            if (pos > ACT_SAT) begin
                pos = ACT_SAT;
            end
            if (k < HALF) begin
                t[HALF + k] = pos[ACT_W-1:0];
            end
            if (k > 0) begin
                t[HALF - k] = r[ACT_W-1:0];
            end
        end
        return t;
    endfunction

    localparam sig_tab_t SIG_TABLE = build_sig_table();

    // ---------------------------------------------------------------- config
    logic [COUNT_W-1:0]       input_count_reg;
    logic signed [BIAS_W-1:0] bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_count_reg <= COUNT_W'(1);
            bias_reg        <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_INPUT_COUNT: input_count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_BIAS:        bias_reg        <= $signed(cfg_wdata[BIAS_W-1:0]);
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------- accept
    logic            in_fire;
    logic            sample_fire;
    logic            weight_fire;
    logic [PW-1:0]   sample_position_reg;
    logic [PW-1:0]   sample_position_next;
    logic [PW-1:0]   pos_cur;
    logic [PW-1:0]   pos_inc;
    logic [CW-1:0]   count_eff;
    logic            last_sample;
    logic            widx_in_range;
    logic [AW-1:0]   waddr;
    logic [OFIFO_CW-1:0] outstanding_reg;

    assign s_ready     = (outstanding_reg < OFIFO_CW'(OFIFO_DEPTH));
    assign in_fire     = s_valid && s_ready;
    assign sample_fire = in_fire && (s_mode == MODE_SAMPLE);
    assign weight_fire = in_fire && (s_mode == MODE_WEIGHT);

    // Effective vector length: zero counts as one, clamp to the weight store
    always_comb begin
        count_eff = CW'(input_count_reg);
        if (count_eff == '0) begin
            count_eff = CW'(1);
        end else if (count_eff > CW'(MAX_INPUTS)) begin
            count_eff = CW'(MAX_INPUTS);
        end
    end

    always_comb begin
        pos_cur = sample_position_reg;
        if (pos_cur >= PW'(MAX_INPUTS)) begin
            pos_cur = PW'(MAX_INPUTS - 1);
        end
        pos_inc     = pos_cur + PW'(1);
        last_sample = (CW'(pos_inc) >= count_eff);
        sample_position_next = sample_position_reg;
        if (sample_fire) begin
            sample_position_next = last_sample ? '0 : pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_position_reg <= '0;
        end else begin
            sample_position_reg <= sample_position_next;
        end
    end

    assign widx_in_range = (32'(s_weight_index) < 32'(MAX_INPUTS));
    assign waddr         = AW'(s_weight_index);

    // ---------------------------------------------------------------- weight memory
    logic [VALUE_W-1:0]        weight_mem [MAX_INPUTS];
    logic signed [VALUE_W-1:0] weight_q_reg;

    always_ff @(posedge aclk) begin
        if (weight_fire && widx_in_range) begin
            weight_mem[waddr] <= s_value;
        end
        if (sample_fire) begin
            weight_q_reg <= $signed(weight_mem[pos_cur[AW-1:0]]);
        end
    end

    // ---------------------------------------------------------------- pipeline
    logic                      p1_valid_reg;
    logic                      p1_last_reg;
    logic signed [VALUE_W-1:0] p1_x_reg;
    logic                      p2_valid_reg;
    logic                      p2_last_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]          sum_acc_reg;
    logic [ACC_W-1:0]          sum_acc_next;
    logic                      p3_valid_reg;
    logic [ACC_W-1:0]          fin_sum_reg;
    logic                      p4_valid_reg;
    logic [TIW-1:0]            tidx_reg;
    logic [TIW-1:0]            tidx_next;
    logic                      p5_valid_reg;
    logic [ACT_W-1:0]          rom_q_reg;
    logic signed [SUM_W-1:0]   full_sum;
    logic signed [IDX_W-1:0]   idx_raw;
    logic signed [IDX_W-1:0]   idx_clamped;

    // Wrap the product into the accumulator
    assign sum_acc_next = sum_acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Add bias in Q.24, floor to 1/32 steps, clamp to the table range
    always_comb begin
        full_sum = $signed({fin_sum_reg[ACC_W-1], fin_sum_reg})
                 + $signed({{(SUM_W - BIAS_W - BIAS_SHIFT){bias_reg[BIAS_W-1]}},
                            bias_reg, {BIAS_SHIFT{1'b0}}});
        idx_raw     = full_sum[SUM_W-1:IDX_SHIFT];
        idx_clamped = idx_raw;
        if (idx_raw < -IDX_W'(HALF)) begin
            idx_clamped = -IDX_W'(HALF);
        end else if (idx_raw > IDX_W'(HALF - 1)) begin
            idx_clamped = IDX_W'(HALF - 1);
        end
        tidx_next = idx_clamped[TIW-1:0] + TIW'(HALF);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            sum_acc_reg  <= '0;
        end else begin
            p1_valid_reg <= sample_fire;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg && p2_last_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            // Clear after the closing sample, else keep summing
            if (p2_valid_reg) begin
                sum_acc_reg <= p2_last_reg ? '0 : sum_acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_fire) begin
            p1_x_reg    <= s_value;
            p1_last_reg <= last_sample;
        end
        prod_reg    <= weight_q_reg * p1_x_reg;
        p2_last_reg <= p1_last_reg;
        if (p2_valid_reg && p2_last_reg) begin
            fin_sum_reg <= sum_acc_next;
        end
        tidx_reg  <= tidx_next;
        rom_q_reg <= SIG_TABLE[tidx_reg];
    end

    // ---------------------------------------------------------------- result buffer
    logic [ACT_W-1:0]    ofifo_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] wr_ptr_reg;
    logic [OFIFO_AW-1:0] rd_ptr_reg;
    logic [OFIFO_CW-1:0] fifo_cnt_reg;
    logic                push;
    logic                pop;

    assign push         = p5_valid_reg;
    assign m_valid      = (fifo_cnt_reg != '0);
    assign pop          = m_valid && m_ready;
    assign m_activation = ofifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            ofifo_mem[wr_ptr_reg] <= rom_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            fifo_cnt_reg    <= '0;
            outstanding_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OFIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OFIFO_AW'(1);
            end
            priority case ({push, pop})
                2'b10:   fifo_cnt_reg <= fifo_cnt_reg + OFIFO_CW'(1);
                2'b01:   fifo_cnt_reg <= fifo_cnt_reg - OFIFO_CW'(1);
                default: ;
            endcase
            // Reserve a slot for each closing sample, free it when the beat leaves
            priority case ({sample_fire && last_sample, pop})
                2'b10:   outstanding_reg <= outstanding_reg + OFIFO_CW'(1);
                2'b01:   outstanding_reg <= outstanding_reg - OFIFO_CW'(1);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    a_outstanding_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding_reg <= OFIFO_CW'(OFIFO_DEPTH))
        else $error("more results outstanding than buffer slots");

    a_fifo_within_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= outstanding_reg)
        else $error("buffer holds more results than were reserved");

    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (sample_fire && last_sample) |-> ##5 p5_valid_reg)
        else $error("closing sample did not reach the result buffer on time");

    a_no_push_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_cnt_reg < OFIFO_CW'(OFIFO_DEPTH)) || pop)
        else $error("result pushed into a full buffer");

endmodule
